// ===== hw/rtl/lpfd_pkg.sv =====
// Shared constants and types for the length-prefixed frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package lpfd_pkg;

  localparam int unsigned HdrLen  = 6;
  localparam int unsigned PosW    = 17;
  localparam int unsigned LenW    = 16;

  localparam logic [7:0] MagicA      = 8'h43;
  localparam logic [7:0] MagicB      = 8'h48;
  localparam logic [7:0] VersionByte = 8'h01;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  // Header offsets
  localparam logic [PosW-1:0] PosMagicA  = 17'd0;
  localparam logic [PosW-1:0] PosMagicB  = 17'd1;
  localparam logic [PosW-1:0] PosVersion = 17'd2;
  localparam logic [PosW-1:0] PosType    = 17'd3;
  localparam logic [PosW-1:0] PosLenHi   = 17'd4;
  localparam logic [PosW-1:0] PosLenLo   = 17'd5;
  localparam logic [PosW-1:0] PosHdrLen  = 17'd6;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StShort   = 3'd1,
    StMagic   = 3'd2,
    StVersion = 3'd3,
    StLength  = 3'd4
  } status_e;

endpackage

`default_nettype wire

// ===== hw/rtl/length_prefixed_frame_decoder_core.sv =====
// Length-prefixed frame decoder: input register, header decode and result register.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a buffer presented one byte per item. A frame is the header 0x43 0x48 0x01,
// a type byte and a big-endian 16-bit length, followed by the payload. Every input
// item gives exactly one result item. Bytes past the six-byte header come out at once
// with payload_valid_o set, before the frame is checked, so drop the payload of any
// buffer whose final status is not ok. The result for the byte flagged last_byte_i
// carries frame_done_o, the status (0 ok, 1 short, 2 bad magic, 3 bad version,
// 4 length mismatch), the type and the declared length; the decoder then clears itself.
// Throughput is one item per clock while the output is not stalled. Each accepted item is
// held in the input register and then moves to the result register, from which it is
// taken. Stall on the output passes back to in_stall_o in the same cycle once
// both registers hold an item.
module length_prefixed_frame_decoder_core
  import lpfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             payload_valid_o,
  output logic [7:0]       payload_byte_o,
  output logic             frame_done_o,
  output logic [2:0]       status_o,
  output logic [7:0]       frame_type_o,
  output logic [15:0]      payload_length_o
);

  // Input register
  logic            in_valid_q, in_valid_d;
  logic [7:0]      in_byte_q;
  logic            in_last_q;

  // Decoder state
  logic [PosW-1:0] pos_q, pos_d;
  status_e         err_q, err_d;
  logic [7:0]      type_q, type_d;
  logic [LenW-1:0] len_q, len_d;

  // Result register
  logic            out_valid_q, out_valid_d;
  logic            res_pvalid_q, res_pvalid_d;
  logic [7:0]      res_pbyte_q, res_pbyte_d;
  logic            res_done_q, res_done_d;
  status_e         res_status_q, res_status_d;
  logic [7:0]      res_type_q, res_type_d;
  logic [LenW-1:0] res_len_q, res_len_d;

  logic            advance;
  logic            take;
  logic            in_load;
  status_e         err_n;
  logic [7:0]      type_n;
  logic [LenW-1:0] len_n;
  status_e         status_n;

  assign advance    = !out_valid_q || !out_stall_i;
  assign take       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  // Header capture and checks for the byte in the input register
  always_comb begin
    err_n  = err_q;
    type_n = type_q;
    len_n  = len_q;
    priority case (pos_q)
      PosMagicA:  if (in_byte_q != MagicA && err_q == StOk) err_n = StMagic;
      PosMagicB:  if (in_byte_q != MagicB && err_q == StOk) err_n = StMagic;
      PosVersion: if (in_byte_q != VersionByte && err_q == StOk) err_n = StVersion;
      PosType:    type_n = in_byte_q;
      PosLenHi:   len_n = {in_byte_q, len_q[7:0]};
      PosLenLo:   len_n = {len_q[15:8], in_byte_q};
      default:    ;
    endcase

    // Count is pos + 1: short means pos < 5, a match means pos == len + 5
    priority if (pos_q < PosLenLo) begin
      status_n = StShort;
    end else if (err_n != StOk) begin
      status_n = err_n;
    end else if (pos_q != ({1'b0, len_n} + PosLenLo)) begin
      status_n = StLength;
    end else begin
      status_n = StOk;
    end
  end

  always_comb begin
    in_valid_d   = in_load ? 1'b1 : (take ? 1'b0 : in_valid_q);
    out_valid_d  = advance ? in_valid_q : out_valid_q;

    pos_d  = pos_q;
    err_d  = err_q;
    type_d = type_q;
    len_d  = len_q;
    if (take) begin
      if (in_last_q) begin
        pos_d  = '0;
        err_d  = StOk;
        type_d = '0;
        len_d  = '0;
      end else begin
        pos_d  = (pos_q != PosMax) ? pos_q + 1'b1 : pos_q;
        err_d  = err_n;
        type_d = type_n;
        len_d  = len_n;
      end
    end

    res_pvalid_d = (pos_q >= PosHdrLen);
    res_pbyte_d  = res_pvalid_d ? in_byte_q : 8'h00;
    res_done_d   = in_last_q;
    res_status_d = in_last_q ? status_n : StOk;
    res_type_d   = in_last_q ? type_n : 8'h00;
    res_len_d    = in_last_q ? len_n : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      err_q       <= StOk;
      type_q      <= '0;
      len_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      err_q       <= err_d;
      type_q      <= type_d;
      len_q       <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
    if (take) begin
      res_pvalid_q <= res_pvalid_d;
      res_pbyte_q  <= res_pbyte_d;
      res_done_q   <= res_done_d;
      res_status_q <= res_status_d;
      res_type_q   <= res_type_d;
      res_len_q    <= res_len_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_valid_o  = res_pvalid_q;
  assign payload_byte_o   = res_pbyte_q;
  assign frame_done_o     = res_done_q;
  assign status_o         = res_status_q;
  assign frame_type_o     = res_type_q;
  assign payload_length_o = res_len_q;

  // State clears after the last byte of a buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_last_q) |=> (pos_q == '0 && err_q == StOk && len_q == '0))
    else $error("decoder state not cleared after last byte");

  // Position advances by one per byte until it saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !in_last_q && pos_q != PosMax) |=> (pos_q == $past(pos_q) + 1'b1))
    else $error("byte position did not advance");

  // Frame fields are zero on results that do not end a buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_done_q) |->
      (res_status_q == StOk && res_type_q == 8'h00 && res_len_q == '0))
    else $error("frame fields set on a non-final result");

endmodule

`default_nettype wire
